/* design/assert_macros.svh */
// Assertion macros shared by the surface synthesis RTL.
// Users must provide clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/cssurf_pkg.sv */
// Shared types and constants for the cosine-series surface synthesizer.
// No dependencies; used by cssurf_finish and the top level.
package cssurf_pkg;

	localparam int DEF_MODES_P = 32;
	localparam int DEF_MODES_Q = 32;
	localparam int DEF_COLS    = 256;
	localparam int DEF_ROWS    = 256;

	localparam int CFG_W   = 6;
	localparam int VAL_W   = 16;
	localparam int RES_W   = 32;
	localparam int SUM_W   = 64;
	localparam int PIX_W   = 8;

	// Configuration register indexes
	localparam logic [1:0] REG_MODES_P = 2'd0;
	localparam logic [1:0] REG_MODES_Q = 2'd1;
	localparam logic [1:0] REG_SHIFT   = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_AMP = 2'd0,
		CMD_LOAD_COL = 2'd1,
		CMD_LOAD_ROW = 2'd2,
		CMD_COMPUTE  = 2'd3
	} cmd_t;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [RES_W-1:0] res_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
	} pix_tag_t;

	typedef struct packed {
		sum_t z;
		sum_t sx;
		sum_t sy;
	} sums_t;

	typedef struct packed {
		res_t z;
		res_t sx;
		res_t sy;
	} results_t;

endpackage

/* design/cssurf_finish.sv */
// Shift-and-saturate back end: two pipeline stages from 64-bit sums to 32-bit results.
// Depends on cssurf_pkg.
module cssurf_finish import cssurf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  pix_tag_t    tag_in,
	input  sums_t       sum_in,
	input  logic [CFG_W-1:0] shift,
	output pix_tag_t    tag_out,
	output results_t    res_out
);

	function automatic res_t sat32(input sum_t x);
		if (x > 64'sd2147483647)
			return res_t'(32'h7fffffff);
		else if (x < -64'sd2147483648)
			return res_t'(32'h80000000);
		else
			return x[RES_W-1:0];
	endfunction

	pix_tag_t tag_s7;
	sums_t    sh_s7;

	// Arithmetic shift (floor)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s7 <= '0;
		end else if (en) begin
			tag_s7 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s7.z    <= sum_in.z >>> shift;
			sh_s7.sx   <= sum_in.sx >>> shift;
			sh_s7.sy   <= sum_in.sy >>> shift;
		end
	end

	// Saturate to 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out.z   <= sat32(sh_s7.z);
			res_out.sx  <= sat32(sh_s7.sx);
			res_out.sy  <= sat32(sh_s7.sy);
		end
	end

endmodule

/* design/cosine_series_surface_synth.sv */
// Cosine-series surface synthesizer, top level.
// Request channel (in_valid/in_stall) carries load and compute commands; loads
// write the amplitude, column-basis or row-basis memories in the accept cycle and
// give no result. A compute request walks the used vertical modes, one per cycle
// unless the output stalls: a row of MAX_MODES_P multiplier pairs forms the
// inner sums over horizontal modes in parallel, then the row basis multiply and
// a 64-bit accumulator finish the pixel. While a compute occupies the mode
// sequencer in_stall is raised; loads are taken every cycle when it is idle and
// the output is not stalled. Result channel (out_valid/out_stall) leaves an
// output register; while it holds a stalled result the whole pipeline freezes
// and in_stall is raised; nothing is lost or repeated. Configuration writes
// (cfg_we/cfg_index/cfg_data) take effect at once and belong to idle periods.
// Reset presets the config registers and clears the sequencer and pipeline valids,
// not the data registers; the memories are not cleared and must be loaded before use.
// Depends on cssurf_pkg, cssurf_finish and assert_macros.svh.
`include "assert_macros.svh"

module cosine_series_surface_synth import cssurf_pkg::*; #(
	parameter int MAX_MODES_P = DEF_MODES_P,
	parameter int MAX_MODES_Q = DEF_MODES_Q,
	parameter int MAX_COLS    = DEF_COLS,
	parameter int MAX_ROWS    = DEF_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic [7:0]              col,
	input  logic [7:0]              row,
	input  logic [4:0]              mode_p,
	input  logic [4:0]              mode_q,
	input  logic signed [VAL_W-1:0] value_a,
	input  logic signed [VAL_W-1:0] value_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_col,
	output logic [7:0]              out_row,
	output logic signed [RES_W-1:0] height,
	output logic signed [RES_W-1:0] slope_x,
	output logic signed [RES_W-1:0] slope_y
);

	localparam int PIW     = (MAX_MODES_P > 1) ? $clog2(MAX_MODES_P) : 1;
	localparam int QIW     = (MAX_MODES_Q > 1) ? $clog2(MAX_MODES_Q) : 1;
	localparam int CIW     = $clog2(MAX_COLS);
	localparam int RIW     = $clog2(MAX_ROWS);
	localparam int PCW     = $clog2(MAX_MODES_P + 1);
	localparam int QCW     = $clog2(MAX_MODES_Q + 1);
	localparam int GRP     = 8;
	localparam int NG      = (MAX_MODES_P + GRP - 1) / GRP;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int GRP_W   = PROD_W + 3;
	localparam int INNER_W = PROD_W + PIW + 1;
	localparam int ROWP_W  = INNER_W + VAL_W;

	// Configuration registers
	logic [CFG_W-1:0] modes_p_q, modes_q_q, shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_p_q <= CFG_W'(32);
			modes_q_q <= CFG_W'(32);
			shift_q   <= CFG_W'(30);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODES_P: modes_p_q <= cfg_data;
				REG_MODES_Q: modes_q_q <= cfg_data;
				REG_SHIFT:   shift_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [PCW-1:0] np_eff;
	logic [QCW-1:0] nq_eff;
	assign np_eff = (32'(modes_p_q) > MAX_MODES_P) ? PCW'(MAX_MODES_P) : PCW'(modes_p_q);
	assign nq_eff = (32'(modes_q_q) > MAX_MODES_Q) ? QCW'(MAX_MODES_Q) : QCW'(modes_q_q);

	// Handshake
	logic adv, in_acc;
	logic issue_q;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = issue_q || !adv;
	assign in_acc   = in_valid && !in_stall;

	// Memories: one wide word per vertical mode, column or row
	logic signed [VAL_W-1:0] amp_mem [MAX_MODES_Q][MAX_MODES_P];
	logic signed [VAL_W-1:0] ccos_mem [MAX_COLS][MAX_MODES_P];
	logic signed [VAL_W-1:0] csin_mem [MAX_COLS][MAX_MODES_P];
	logic signed [VAL_W-1:0] rcos_mem [MAX_ROWS][MAX_MODES_Q];
	logic signed [VAL_W-1:0] rsin_mem [MAX_ROWS][MAX_MODES_Q];

	logic mp_ok, mq_ok, col_in_ok, row_in_ok;
	assign mp_ok     = 32'(mode_p) < MAX_MODES_P;
	assign mq_ok     = 32'(mode_q) < MAX_MODES_Q;
	assign col_in_ok = 32'(col) < MAX_COLS;
	assign row_in_ok = 32'(row) < MAX_ROWS;

	// Write loads
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (cmd)
				CMD_LOAD_AMP: begin
					if (mp_ok && mq_ok)
						amp_mem[QIW'(mode_q)][PIW'(mode_p)] <= value_a;
				end
				CMD_LOAD_COL: begin
					if (col_in_ok && mp_ok) begin
						ccos_mem[CIW'(col)][PIW'(mode_p)] <= value_a;
						csin_mem[CIW'(col)][PIW'(mode_p)] <= value_b;
					end
				end
				CMD_LOAD_ROW: begin
					if (row_in_ok && mq_ok) begin
						rcos_mem[RIW'(row)][QIW'(mode_q)] <= value_a;
						rsin_mem[RIW'(row)][QIW'(mode_q)] <= value_b;
					end
				end
				default: ;
			endcase
		end
	end

	// Mode sequencer
	logic [QCW-1:0] q_q, nq_q;
	logic [PCW-1:0] np_q;
	logic [7:0]     col_q, row_q;
	logic           col_ok_q, row_ok_q;
	logic           last_iss;

	assign last_iss = QCW'(q_q + 1'b1) >= nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			q_q     <= '0;
		end else if (adv) begin
			if (in_acc && cmd == CMD_COMPUTE) begin
				issue_q <= 1'b1;
				q_q     <= '0;
			end else if (issue_q && last_iss) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				q_q <= QCW'(q_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_COMPUTE) begin
			col_q    <= col;
			row_q    <= row;
			col_ok_q <= col_in_ok;
			row_ok_q <= row_in_ok;
			nq_q     <= nq_eff;
			np_q     <= np_eff;
		end
	end

	// Stage 1: memory reads
	pix_tag_t                tag_s1;
	logic                    first_s1, last_s1, rzero_s1;
	logic [MAX_MODES_P-1:0]  pmask_s1;
	logic signed [VAL_W-1:0] amp_s1 [MAX_MODES_P];
	logic signed [VAL_W-1:0] cc_s1 [MAX_MODES_P];
	logic signed [VAL_W-1:0] cs_s1 [MAX_MODES_P];
	logic signed [VAL_W-1:0] rc_s1, rs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s1 <= '0;
		else if (adv)
			tag_s1 <= '{valid: issue_q, col: col_q, row: row_q};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1   <= (q_q == '0);
			last_s1    <= last_iss;
			rzero_s1   <= !row_ok_q || (nq_q == '0);
			for (int p = 0; p < MAX_MODES_P; p++) begin
				pmask_s1[p] <= col_ok_q && (p < 32'(np_q));
				amp_s1[p]   <= amp_mem[q_q[QIW-1:0]][p];
				cc_s1[p]    <= ccos_mem[CIW'(col_q)][p];
				cs_s1[p]    <= csin_mem[CIW'(col_q)][p];
			end
			rc_s1 <= rcos_mem[RIW'(row_q)][q_q[QIW-1:0]];
			rs_s1 <= rsin_mem[RIW'(row_q)][q_q[QIW-1:0]];
		end
	end

	// Stage 2: multiplier row
	pix_tag_t                 tag_s2;
	logic                     first_s2, last_s2;
	logic signed [PROD_W-1:0] pc_s2 [MAX_MODES_P];
	logic signed [PROD_W-1:0] ps_s2 [MAX_MODES_P];
	logic signed [VAL_W-1:0]  rc_s2, rs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s2 <= '0;
		else if (adv)
			tag_s2 <= tag_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s2   <= first_s1;
			last_s2    <= last_s1;
			for (int p = 0; p < MAX_MODES_P; p++) begin
				pc_s2[p] <= pmask_s1[p] ? PROD_W'(amp_s1[p]) * PROD_W'(cc_s1[p]) : '0;
				ps_s2[p] <= pmask_s1[p] ? PROD_W'(amp_s1[p]) * PROD_W'(cs_s1[p]) : '0;
			end
			rc_s2 <= rzero_s1 ? '0 : rc_s1;
			rs_s2 <= rzero_s1 ? '0 : rs_s1;
		end
	end

	// Stage 3: sum groups of eight products
	pix_tag_t                 tag_s3;
	logic                     first_s3, last_s3;
	logic signed [GRP_W-1:0]  gc_s3 [NG];
	logic signed [GRP_W-1:0]  gs_s3 [NG];
	logic signed [VAL_W-1:0]  rc_s3, rs_s3;
	logic signed [GRP_W-1:0]  gc_d [NG];
	logic signed [GRP_W-1:0]  gs_d [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gc_d[g] = '0;
			gs_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < MAX_MODES_P) begin
					gc_d[g] = gc_d[g] + GRP_W'(pc_s2[g * GRP + k]);
					gs_d[g] = gs_d[g] + GRP_W'(ps_s2[g * GRP + k]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s3 <= '0;
		else if (adv)
			tag_s3 <= tag_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s3   <= first_s2;
			last_s3    <= last_s2;
			gc_s3      <= gc_d;
			gs_s3      <= gs_d;
			rc_s3      <= rc_s2;
			rs_s3      <= rs_s2;
		end
	end

	// Stage 4: inner sums over groups
	pix_tag_t                  tag_s4;
	logic                      first_s4, last_s4;
	logic signed [INNER_W-1:0] ic_s4, is_s4;
	logic signed [VAL_W-1:0]   rc_s4, rs_s4;
	logic signed [INNER_W-1:0] ic_d, is_d;

	always_comb begin
		ic_d = '0;
		is_d = '0;
		for (int g = 0; g < NG; g++) begin
			ic_d = ic_d + INNER_W'(gc_s3[g]);
			is_d = is_d + INNER_W'(gs_s3[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s4 <= '0;
		else if (adv)
			tag_s4 <= tag_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s4   <= first_s3;
			last_s4    <= last_s3;
			ic_s4      <= ic_d;
			is_s4      <= is_d;
			rc_s4      <= rc_s3;
			rs_s4      <= rs_s3;
		end
	end

	// Stage 5: row basis multiply
	pix_tag_t                 tag_s5;
	logic                     first_s5, last_s5;
	logic signed [ROWP_W-1:0] tz_s5, tx_s5, ty_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s5 <= '0;
		else if (adv)
			tag_s5 <= tag_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s5   <= first_s4;
			last_s5    <= last_s4;
			tz_s5      <= ROWP_W'(ic_s4) * ROWP_W'(rc_s4);
			tx_s5      <= ROWP_W'(is_s4) * ROWP_W'(rc_s4);
			ty_s5      <= ROWP_W'(ic_s4) * ROWP_W'(rs_s4);
		end
	end

	// Stage 6: accumulate over vertical modes
	sums_t    acc_q, acc_d, sum_s6;
	pix_tag_t tag_s6;

	always_comb begin
		acc_d.z  = (first_s5 ? '0 : acc_q.z) + SUM_W'(tz_s5);
		acc_d.sx = (first_s5 ? '0 : acc_q.sx) + SUM_W'(tx_s5);
		acc_d.sy = (first_s5 ? '0 : acc_q.sy) + SUM_W'(ty_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s6 <= '0;
		else if (adv)
			tag_s6 <= '{valid: tag_s5.valid && last_s5, col: tag_s5.col, row: tag_s5.row};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s6     <= acc_d;
			if (tag_s5.valid)
				acc_q <= acc_d;
		end
	end

	// Stages 7-8: shift and saturate
	pix_tag_t tag_s8;
	results_t res_s8;

	cssurf_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.tag_in  (tag_s6),
		.sum_in  (sum_s6),
		.shift   (shift_q),
		.tag_out (tag_s8),
		.res_out (res_s8)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= tag_s8.valid;
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s8.valid) begin
			out_col <= tag_s8.col;
			out_row <= tag_s8.row;
			height  <= res_s8.z;
			slope_x <= res_s8.sx;
			slope_y <= res_s8.sy;
		end
	end

	// Checks
	`ASSERT_NEXT(a_issue_ends, issue_q && last_iss && adv, !issue_q)
	`ASSERT_IMPL(a_mode_range, issue_q, (q_q < nq_q) || (nq_q == '0 && q_q == '0))
	`ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(height))

endmodule
